### src/wmsh_pkg.sv
// Shared constants, FSM state type and controller/datapath command and
// status structs for the window minimum subsequence hash. No dependencies.
package wmsh_pkg;

   localparam int WMSH_WINDOW_LEN = 16;
   localparam int WMSH_CHOSEN     = 8;

   localparam int POS_W  = 20;
   localparam int HASH_W = 16;
   localparam int MASK_W = 16;
   localparam int TERM_W = 32;   // 2-bit code shifted by up to 30
   localparam int CFG_W  = 64;

   localparam logic [HASH_W-1:0] HASH_MAX = 16'hFFFF;
   localparam logic [CFG_W-1:0]  SHIFT_ORDER_RESET = 64'h0000_0000_7654_3210;

   // csr register indexes
   localparam logic CSR_CODE_TABLE  = 1'b0;
   localparam logic CSR_SHIFT_ORDER = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;       // take the offered word into the window
      logic row_step;   // run one DP row
      logic finish;     // compute hash, dedupe, load output register
   } cmd_type;

   typedef struct packed {
      logic full_next;  // window is full after the offered base
      logic row_last;   // current row is the last of the window
      logic out_free;   // output register can take a word this cycle
   } status_type;

endpackage

### src/wmsh_if.sv
// Valid/ready channel interfaces for input bases and hash results.
// Depends on nothing.
interface wmsh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] base;
   logic       read_start;

   modport source (output valid, output base, output read_start, input ready);
   modport sink   (input valid, input base, input read_start, output ready);
endinterface

interface wmsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] hash_value;
   logic [19:0] window_start;
   logic [15:0] chosen_mask;

   modport source (output valid, output hash_value, output window_start,
                   output chosen_mask, input ready);
   modport sink   (input valid, input hash_value, input window_start,
                   input chosen_mask, output ready);
endinterface

### src/window_min_subsequence_hash.sv
// Top level of the window minimum subsequence hash.
// Depends on wmsh_pkg, wmsh_if, wmsh_ctrl and wmsh_dp.

// Takes one 2-bit base word per accept and keeps the last WINDOW_LEN bases of
// the current read. A word with read_start set opens a new read: window,
// position and repeat filter are cleared before that base goes in. Until the
// window is full a base yields nothing. Once full, each base runs the DP one
// row per cycle over the window on the single row of CHOSEN add/compare
// cells, then a finish step that waits while the result register is full;
// a new base is accepted only after that finish step. The result word
// carries the minimum weighted value (saturated to 16 bits), the read
// position of the window's first base and a mask of chosen offsets; it is
// dropped when hash and last chosen position both match the previous
// result of the same read. The result register lets a new base be
// accepted while a word waits.
// csr_index 0 writes code_table, 1 writes shift_order; write only when idle.
module window_min_subsequence_hash #(
   parameter int WINDOW_LEN = wmsh_pkg::WMSH_WINDOW_LEN,
   parameter int CHOSEN     = wmsh_pkg::WMSH_CHOSEN
) (
   input  logic                       clock,
   input  logic                       reset,
   wmsh_req_if.sink                   req_chan,
   wmsh_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [wmsh_pkg::CFG_W-1:0] csr_wdata
);
   import wmsh_pkg::*;

   cmd_type    cmd;
   status_type status;

   // FSM: idle / row sweep / finish
   wmsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // window, DP row cells, repeat filter and result register
   wmsh_dp #(
      .WINDOW_LEN (WINDOW_LEN),
      .CHOSEN     (CHOSEN)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_base         (req_chan.base),
      .req_read_start   (req_chan.read_start),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_hash_value   (rsp_chan.hash_value),
      .rsp_window_start (rsp_chan.window_start),
      .rsp_chosen_mask  (rsp_chan.chosen_mask)
   );

endmodule

### src/wmsh_ctrl.sv
// Controller FSM: sequences load, DP rows and the finish step.
// Depends on wmsh_pkg.
module wmsh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output wmsh_pkg::cmd_type    cmd,
   input  wmsh_pkg::status_type status
);
   import wmsh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.full_next) begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            cmd.row_step = 1'b1;
            if (status.row_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/wmsh_dp.sv
// Datapath: base window, config registers, one DP row of CHOSEN cells per
// step, dedupe state and the result register. Depends on wmsh_pkg.
module wmsh_dp #(
   parameter int WINDOW_LEN = wmsh_pkg::WMSH_WINDOW_LEN,
   parameter int CHOSEN     = wmsh_pkg::WMSH_CHOSEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      req_base,
   input  logic                            req_read_start,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [wmsh_pkg::CFG_W-1:0]      csr_wdata,
   input  wmsh_pkg::cmd_type                cmd,
   output wmsh_pkg::status_type             status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wmsh_pkg::HASH_W-1:0]     rsp_hash_value,
   output logic [wmsh_pkg::POS_W-1:0]      rsp_window_start,
   output logic [wmsh_pkg::MASK_W-1:0]     rsp_chosen_mask
);
   import wmsh_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int ROW_W  = $clog2(WINDOW_LEN);
   localparam int COST_W = TERM_W + $clog2(CHOSEN);
   localparam int SLACK  = WINDOW_LEN - CHOSEN;

   logic [CFG_W-1:0]      code_ff, code_in;
   logic [CFG_W-1:0]      shift_ff, shift_in;
   logic [1:0]            win_ff [WINDOW_LEN];
   logic [1:0]            win_in [WINDOW_LEN];
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      st_ff, st_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COST_W-1:0]     cost_ff [CHOSEN];
   logic [COST_W-1:0]     cost_in [CHOSEN];
   logic [WINDOW_LEN-1:0] mask_ff [CHOSEN];
   logic [WINDOW_LEN-1:0] mask_in [CHOSEN];
   logic [ROW_W-1:0]      end_ff, end_in;
   logic                  last_valid_ff, last_valid_in;
   logic [HASH_W-1:0]     last_hash_ff, last_hash_in;
   logic [POS_W-1:0]      last_end_ff, last_end_in;
   logic                  out_valid_ff, out_valid_in;
   logic [HASH_W-1:0]     out_hash_ff, out_hash_in;
   logic [POS_W-1:0]      out_start_ff, out_start_in;
   logic [MASK_W-1:0]     out_mask_ff, out_mask_in;

   logic [1:0]            row_base;
   logic [TERM_W-1:0]     term_w [CHOSEN];
   logic [COST_W-1:0]     cand_w [CHOSEN];
   logic                  take_w [CHOSEN];
   logic [HASH_W-1:0]     hash_w;
   logic [POS_W-1:0]      end_pos_w;
   logic                  dup_w;

   assign row_base = win_ff[row_ff];

   // per-lane weighted term and candidate: lane l is DP column l+1
   always_comb begin
      for (int l = 0; l < CHOSEN; l++) begin
         term_w[l] = TERM_W'(2'(code_ff[8*l +: 8] >> {row_base, 1'b0}))
                     << {shift_ff[4*l +: 4], 1'b0};
         cand_w[l] = ((l == 0) ? '0 : cost_ff[(l == 0) ? 0 : l - 1])
                     + COST_W'(term_w[l]);
         take_w[l] = (l <= int'(row_ff)) && (l + SLACK >= int'(row_ff))
                     && ((l == int'(row_ff)) || (cand_w[l] < cost_ff[l]));
      end
   end

   assign hash_w    = (cost_ff[CHOSEN-1] > COST_W'(HASH_MAX)) ? HASH_MAX
                                                                : cost_ff[CHOSEN-1][HASH_W-1:0];
   assign end_pos_w = st_ff + POS_W'(end_ff);
   assign dup_w     = last_valid_ff && (hash_w == last_hash_ff) && (end_pos_w == last_end_ff);

   always_comb begin
      code_in       = code_ff;
      shift_in      = shift_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      st_in         = st_ff;
      row_in        = row_ff;
      cost_in       = cost_ff;
      mask_in       = mask_ff;
      end_in        = end_ff;
      last_valid_in = last_valid_ff;
      last_hash_in  = last_hash_ff;
      last_end_in   = last_end_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_hash_in   = out_hash_ff;
      out_start_in  = out_start_ff;
      out_mask_in   = out_mask_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_TABLE:  code_in  = csr_wdata;
            CSR_SHIFT_ORDER: shift_in = csr_wdata;
            default: ;
         endcase
      end

      // window shift; a read start empties the window first
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
         win_in[k] = req_read_start ? 2'd0 : win_ff[k+1];
      end
      win_in[WINDOW_LEN-1] = req_base;
      if (req_read_start) begin
         fill_in = FILL_W'(1);
         st_in   = POS_W'(0) - POS_W'(WINDOW_LEN - 1);
         pos_in  = POS_W'(1);
      end else begin
         fill_in = (fill_ff < FILL_W'(WINDOW_LEN)) ? fill_ff + 1'b1 : fill_ff;
         st_in   = pos_ff - POS_W'(WINDOW_LEN - 1);
         pos_in  = pos_ff + 1'b1;
      end
      status.full_next = (fill_in == FILL_W'(WINDOW_LEN));
      status.row_last  = (row_ff == ROW_W'(WINDOW_LEN - 1));
      status.out_free  = !out_valid_ff || rsp_ready;

      if (cmd.load) begin
         if (req_read_start) begin
            last_valid_in = 1'b0;
         end
         row_in = '0;
      end else begin
         win_in  = win_ff;
         fill_in = fill_ff;
         pos_in  = pos_ff;
         st_in   = st_ff;
      end

      if (cmd.row_step) begin
         row_in = row_ff + 1'b1;
         for (int l = 0; l < CHOSEN; l++) begin
            if (take_w[l]) begin
               cost_in[l] = cand_w[l];
               mask_in[l] = ((l == 0) ? '0 : mask_ff[(l == 0) ? 0 : l - 1])
                            | (WINDOW_LEN'(1) << row_ff);
            end
         end
         if (take_w[CHOSEN-1]) begin
            end_in = row_ff;
         end
      end

      if (cmd.finish && !dup_w) begin
         last_valid_in = 1'b1;
         last_hash_in  = hash_w;
         last_end_in   = end_pos_w;
         out_valid_in  = 1'b1;
         out_hash_in   = hash_w;
         out_start_in  = st_ff;
         out_mask_in   = MASK_W'(mask_ff[CHOSEN-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff       <= '0;
         shift_ff      <= SHIFT_ORDER_RESET;
         fill_ff       <= '0;
         pos_ff        <= '0;
         last_valid_ff <= 1'b0;
         last_hash_ff  <= '0;
         last_end_ff   <= '0;
         out_valid_ff  <= 1'b0;
         for (int k = 0; k < WINDOW_LEN; k++) begin
            win_ff[k] <= 2'd0;
         end
      end else begin
         code_ff       <= code_in;
         shift_ff      <= shift_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         last_valid_ff <= last_valid_in;
         last_hash_ff  <= last_hash_in;
         last_end_ff   <= last_end_in;
         out_valid_ff  <= out_valid_in;
         win_ff        <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff        <= st_in;
      row_ff       <= row_in;
      cost_ff      <= cost_in;
      mask_ff      <= mask_in;
      end_ff       <= end_in;
      out_hash_ff  <= out_hash_in;
      out_start_ff <= out_start_in;
      out_mask_ff  <= out_mask_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hash_value   = out_hash_ff;
   assign rsp_window_start = out_start_ff;
   assign rsp_chosen_mask  = out_mask_ff;

endmodule

### src/wmsh_checker.sv
// Port-level checks for window_min_subsequence_hash, bound to the top level.
// Depends on wmsh_pkg and the top level's ports.
module wmsh_checker #(
   parameter int CHOSEN = wmsh_pkg::WMSH_CHOSEN
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wmsh_pkg::HASH_W-1:0] rsp_hash_value,
   input logic [wmsh_pkg::POS_W-1:0]  rsp_window_start,
   input logic [wmsh_pkg::MASK_W-1:0] rsp_chosen_mask
);
   import wmsh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash_value) && $stable(rsp_window_start)
                                  && $stable(rsp_chosen_mask))
      else $error("stalled result word changed");

   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_chosen_mask) == CHOSEN)
      else $error("chosen mask does not hold CHOSEN offsets");

   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a finish step");

endmodule

bind window_min_subsequence_hash wmsh_checker #(.CHOSEN(CHOSEN)) u_wmsh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_hash_value   (rsp_chan.hash_value),
   .rsp_window_start (rsp_chan.window_start),
   .rsp_chosen_mask  (rsp_chan.chosen_mask)
);

### tb/sv/window_min_subsequence_hash_tb.sv
// Self-checking testbench for window_min_subsequence_hash.
// Depends on wmsh_pkg, wmsh_if (req/rsp channel interfaces) and the block's RTL.
module window_min_subsequence_hash_tb;
   import wmsh_pkg::*;

   localparam int WLEN  = WMSH_WINDOW_LEN;
   localparam int NSEL  = WMSH_CHOSEN;
   localparam int LIMIT = 600000;   // cycles; slowest correct run is far below
   localparam int DUE_DEPTH = 64;   // expected words in flight, ring buffer
   localparam int NROWS = WLEN + 3;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic [POS_W-1:0]  window_start;
      logic [MASK_W-1:0] chosen_mask;
   } hash_word_t;

   typedef struct {
      logic [1:0] base;
      logic       read_start;
      bit         typed;       // expected word typed in below
      hash_word_t word;
   } base_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_CODE_TABLE;
   logic [CFG_W-1:0] csr_wdata = '0;

   wmsh_req_if req ();
   wmsh_rsp_if rsp ();

   window_min_subsequence_hash DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req.sink),
      .rsp_chan  (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the window, filter and registers
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]  code_tab;
   logic [CFG_W-1:0]  slot_digits;
   logic [1:0]        win [WLEN];
   int                fill;
   logic [POS_W-1:0]  pos;
   logic [HASH_W-1:0] prev_hash;
   logic [POS_W-1:0]  prev_end;
   bit                prev_valid;

   hash_word_t due_words [DUE_DEPTH];
   int  due_wr = 0;
   int  due_rd = 0;
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_left = 0;
   longint cycles = 0;

   task automatic report(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic add_due(input hash_word_t w);
      due_words[due_wr % DUE_DEPTH] = w;
      due_wr++;
   endtask

   // weight of base b taken as the slot-th chosen base
   function automatic longint unsigned slot_weight(int slot, logic [1:0] b);
      longint unsigned code;
      int digit;
      code  = (code_tab >> (8 * slot + 2 * b)) & 64'd3;
      digit = int'((slot_digits >> (4 * slot)) & 64'd15);
      return code << (2 * digit);
   endfunction

   // advance the window by one base; returns 1 with the word if one is due
   function automatic bit min_hash_step(input logic [1:0] b, input logic rs,
                                        output hash_word_t word);
      longint unsigned cost [NSEL+1];
      logic [3:0] ptr [WLEN][NSEL];
      longint unsigned cand;
      logic [POS_W-1:0] cur, st, end_pos;
      logic [HASH_W-1:0] hv;
      logic [MASK_W-1:0] mask;
      int lo, hi, x, y, off;
      bit first;
      word = '0;
      if (rs) begin
         foreach (win[k]) win[k] = 2'd0;
         fill = 0;
         pos = '0;
         prev_valid = 0;
      end
      for (int k = 0; k < WLEN - 1; k++) win[k] = win[k+1];
      win[WLEN-1] = b;
      if (fill < WLEN) fill++;
      cur = pos;
      pos = pos + 1'b1;
      if (fill < WLEN) return 0;
      st = cur - POS_W'(WLEN - 1);

      cost[0] = 0;
      cost[1] = slot_weight(0, win[0]);
      ptr[0][0] = 4'd0;
      for (int i = 2; i <= WLEN; i++) begin
         lo = (i > WLEN - NSEL + 1) ? i - (WLEN - NSEL) : 1;
         hi = (i < NSEL) ? i : NSEL;
         for (int j = hi; j >= lo && j >= 1; j--) begin
            cand = cost[j-1] + slot_weight(j - 1, win[i-1]);
            // strict less: ties keep the earlier offset
            if (j == i || cand < cost[j]) begin
               cost[j] = cand;
               ptr[i-1][j-1] = 4'(i - 1);
            end else begin
               ptr[i-1][j-1] = ptr[i-2][j-1];
            end
         end
      end
      hv = (cost[NSEL] > 64'hFFFF) ? HASH_MAX : HASH_W'(cost[NSEL]);

      mask = '0;
      end_pos = '0;
      first = 1;
      x = WLEN;
      y = NSEL;
      while (y > 0 && x > 0) begin
         off = ptr[x-1][y-1];
         mask[off] = 1'b1;
         if (first) begin
            end_pos = st + POS_W'(off);
            first = 0;
         end
         x = off;
         y--;
      end

      // repeat filter: same hash and same last chosen position
      if (prev_valid && hv == prev_hash && end_pos == prev_end) return 0;
      prev_valid = 1;
      prev_hash = hv;
      prev_end = end_pos;
      word.hash_value = hv;
      word.window_start = st;
      word.chosen_mask = mask;
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side: drive at falling edge, take acceptance at rising edge.
   // valid stays up after an accept until the next falling edge decides.
   // ---------------------------------------------------------------------
   task automatic send_base(input logic [1:0] b, input logic rs,
                            input bit typed, input hash_word_t typed_word);
      hash_word_t w;
      bit due;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.base <= b;
      req.read_start <= rs;
      do @(posedge clock); while (!req.ready);
      due = min_hash_step(b, rs, w);
      if (typed) add_due(typed_word);
      else if (due) add_due(w);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CODE_TABLE) code_tab = data;
      else slot_digits = data;
      @(negedge clock);
   endtask

   // all words in, then cover a base still in flight that yields nothing
   task automatic drain();
      req.valid <= 1'b0;
      while (due_wr != due_rd) @(negedge clock);
      repeat (3 * WLEN) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random ready, long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      hash_word_t exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (due_wr == due_rd) begin
            report($sformatf("unexpected word hash=%h start=%h mask=%h",
                             rsp.hash_value, rsp.window_start, rsp.chosen_mask));
         end else begin
            exp_w = due_words[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp.hash_value !== exp_w.hash_value)
               report($sformatf("hash_value %h, want %h", rsp.hash_value,
                                exp_w.hash_value));
            if (rsp.window_start !== exp_w.window_start)
               report($sformatf("window_start %h, want %h", rsp.window_start,
                                exp_w.window_start));
            if (rsp.chosen_mask !== exp_w.chosen_mask)
               report($sformatf("chosen_mask %h, want %h", rsp.chosen_mask,
                                exp_w.chosen_mask));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed rows. With code_table at reset every weight is zero, so the
   // DP ties everywhere and keeps offsets 0..7: hash 0, mask 00FF.
   // ---------------------------------------------------------------------
   base_row_t rows [NROWS];

   initial begin
      hash_word_t none;
      logic [CFG_W-1:0] perm;
      int order [NSEL];
      int tmp, k, since_start, r;
      bit rs;
      logic [1:0] b;

      none = '0;
      req.valid = 1'b0;
      req.base = 2'd0;
      req.read_start = 1'b0;
      rsp.ready = 1'b0;
      code_tab = '0;
      slot_digits = SHIFT_ORDER_RESET;
      foreach (win[i]) win[i] = 2'd0;
      fill = 0;
      pos = '0;
      prev_hash = '0;
      prev_end = '0;
      prev_valid = 0;

      // fill of the first read: nothing until the window is full
      r = 0;
      for (int i = 0; i < WLEN - 1; i++) begin
         rows[r] = '{2'(i), (i == 0), 1'b0, none};
         r++;
      end
      rows[r] = '{2'd3, 1'b0, 1'b1, '{16'h0000, 20'h00000, 16'h00FF}};
      r++;
      rows[r] = '{2'd0, 1'b0, 1'b1, '{16'h0000, 20'h00001, 16'h00FF}};
      r++;
      rows[r] = '{2'd2, 1'b0, 1'b1, '{16'h0000, 20'h00002, 16'h00FF}};
      r++;
      // new read mid-stream: window restarts, nothing due
      rows[r] = '{2'd3, 1'b1, 1'b1, none};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 52;
      foreach (rows[i]) begin
         if (rows[i].typed && rows[i].word == none)
            send_base(rows[i].base, rows[i].read_start, 1'b0, none);
         else
            send_base(rows[i].base, rows[i].read_start, rows[i].typed, rows[i].word);
      end
      drain();

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 29 : (p < 4) ? 52 : 0;
         recv_idle_pct = (p < 2) ? 52 : (p < 4) ? 29 : 0;
         case (p)
            0: begin
               write_csr(CSR_CODE_TABLE, {$urandom, $urandom});
               write_csr(CSR_SHIFT_ORDER, SHIFT_ORDER_RESET);
            end
            1: begin
               write_csr(CSR_CODE_TABLE, '1);
               write_csr(CSR_SHIFT_ORDER, '0);   // every slot at the same digit
            end
            2: begin
               write_csr(CSR_CODE_TABLE, {$urandom, $urandom});
               write_csr(CSR_SHIFT_ORDER, {$urandom, $urandom});
            end
            3: begin
               // top digit everywhere: sums overflow 16 bits, hash saturates
               write_csr(CSR_CODE_TABLE, '1);
               write_csr(CSR_SHIFT_ORDER, '1);
            end
            4: begin
               foreach (order[i]) order[i] = i;
               for (int i = NSEL - 1; i > 0; i--) begin
                  k = $urandom_range(i);
                  tmp = order[i];
                  order[i] = order[k];
                  order[k] = tmp;
               end
               perm = '0;
               foreach (order[i]) perm[4*i +: 4] = 4'(order[i]);
               write_csr(CSR_CODE_TABLE, {$urandom, $urandom});
               write_csr(CSR_SHIFT_ORDER, perm);
            end
            default: begin
               write_csr(CSR_CODE_TABLE, {$urandom, $urandom});
               write_csr(CSR_SHIFT_ORDER, SHIFT_ORDER_RESET);
            end
         endcase

         // long receiver stall so the result register fills and input backs up
         if (p == 1) hold_left = 400;

         since_start = 0;
         for (int n = 0; n < 122; n++) begin
            // mostly long reads; the odd early restart as noise
            rs = (n == 0) || (since_start > 40 && $urandom_range(99) < 3) ||
                 ($urandom_range(199) == 0);
            since_start = rs ? 0 : since_start + 1;
            // runs of one base make repeated windows likely
            b = ($urandom_range(99) < 25) ? 2'd0 : 2'($urandom_range(3));
            send_base(b, rs, 1'b0, none);
         end
         drain();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
